>>> hw/rtl/dlac_pkg.sv
package dlac_pkg;

  typedef enum logic [2:0] {
    MODE_LOCKED   = 3'd0,
    MODE_UNLOCKED = 3'd1,
    MODE_OPENED   = 3'd2,
    MODE_CLOSEDW  = 3'd3,
    MODE_WAITCL   = 3'd4,
    MODE_ALARM    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    MSG_NONE    = 3'd0,
    MSG_BREACH  = 3'd1,
    MSG_UNLOCK  = 3'd2,
    MSG_OPENED  = 3'd3,
    MSG_CLOSED  = 3'd4,
    MSG_WARNING = 3'd5,
    MSG_CLOSEDR = 3'd6,
    MSG_INPUT   = 3'd7
  } msg_t;

  typedef enum logic [2:0] {
    CFG_FSM_ENABLE   = 3'd0,
    CFG_UNLOCK_TICKS = 3'd1,
    CFG_OPEN_TIMEOUT = 3'd2,
    CFG_ALARM_TICKS  = 3'd3,
    CFG_CLOSED_SHOW  = 3'd4,
    CFG_BLINK_TICKS  = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W = 16;

  localparam logic [TICK_W-1:0] UNLOCK_TICKS_RST = 16'd500;
  localparam logic [TICK_W-1:0] OPEN_TIMEOUT_RST = 16'd1000;
  localparam logic [TICK_W-1:0] ALARM_TICKS_RST  = 16'd3000;
  localparam logic [TICK_W-1:0] CLOSED_SHOW_RST  = 16'd100;
  localparam logic [TICK_W-1:0] BLINK_TICKS_RST  = 16'd20;

  typedef struct packed {
    logic door_open;
    logic intruder_alarm;
    logic correct_event;
  } dlac_in_t;

  typedef struct packed {
    logic       solenoid_on;
    logic       red_led;
    logic       green_led;
    logic       buzzer_on;
    logic [2:0] door_mode;
    logic       unlocked_or_open;
    logic [2:0] message;
  } dlac_out_t;

  typedef struct packed {
    logic              fsm_enable;
    logic [TICK_W-1:0] unlock_ticks;
    logic [TICK_W-1:0] open_timeout_ticks;
    logic [TICK_W-1:0] alarm_ticks;
    logic [TICK_W-1:0] closed_show_ticks;
    logic [TICK_W-1:0] blink_ticks;
  } dlac_cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [TICK_W-1:0] countdown;
    logic              expired;
    logic              unlock_shown;
    logic [TICK_W-1:0] blink_count;
    logic              solenoid;
    logic              red;
    logic              green;
    logic              buzzer;
  } dlac_state_t;

endpackage

>>> hw/rtl/door_lock_alarm_controller_core.sv
// Channel | Ports                              | Moves
// --------+------------------------------------+----------------------------------
// in      | in_valid, in_stall, in_data        | one timer tick (door, alarm, pw ok)
// out     | out_valid, out_stall, out_data     | latches, mode and message after tick
// cfg     | cfg_we, cfg_index, cfg_wdata       | register write, no read-back
//
// One tick per cycle while in_stall is low. The next state and the result are worked out in one
// pass of logic from the state registers and the incoming tick; the result
// is captured in the output register on the transfer.
// A new tick is taken while the output register is empty or being drained,
// so a stall on out backs up into in_stall only when a result is waiting.
// Reset (rst_n low, synchronous) restores state, valid and cfg registers; out_data is not reset.
module door_lock_alarm_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dlac_pkg::dlac_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dlac_pkg::dlac_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [dlac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dlac_pkg::*;

  dlac_cfg_t   cfg;
  dlac_state_t st_r, st_nxt;
  dlac_out_t   res_nxt;
  dlac_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_xfer;

  dlac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  dlac_step u_step (
    .st_i   (st_r),
    .cfg_i  (cfg),
    .tick_i (in_data),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // hold off only when the result register is full and not being taken
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // controller state; green starts on as a lamp test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= MODE_LOCKED;
      st_r.countdown    <= '0;
      st_r.expired      <= 1'b0;
      st_r.unlock_shown <= 1'b0;
      st_r.blink_count  <= '0;
      st_r.solenoid     <= 1'b0;
      st_r.red          <= 1'b1;
      st_r.green        <= 1'b1;
      st_r.buzzer       <= 1'b0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/dlac_cfg.sv
module dlac_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dlac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dlac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output dlac_pkg::dlac_cfg_t                 cfg_o
);
  import dlac_pkg::*;

  dlac_cfg_t cfg_r;

  // indexes six and seven are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fsm_enable         <= 1'b1;
      cfg_r.unlock_ticks       <= UNLOCK_TICKS_RST;
      cfg_r.open_timeout_ticks <= OPEN_TIMEOUT_RST;
      cfg_r.alarm_ticks        <= ALARM_TICKS_RST;
      cfg_r.closed_show_ticks  <= CLOSED_SHOW_RST;
      cfg_r.blink_ticks        <= BLINK_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FSM_ENABLE:   cfg_r.fsm_enable         <= cfg_wdata[0];
        CFG_UNLOCK_TICKS: cfg_r.unlock_ticks       <= cfg_wdata;
        CFG_OPEN_TIMEOUT: cfg_r.open_timeout_ticks <= cfg_wdata;
        CFG_ALARM_TICKS:  cfg_r.alarm_ticks        <= cfg_wdata;
        CFG_CLOSED_SHOW:  cfg_r.closed_show_ticks  <= cfg_wdata;
        CFG_BLINK_TICKS:  cfg_r.blink_ticks        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

>>> hw/rtl/dlac_step.sv
module dlac_step (
  input  dlac_pkg::dlac_state_t st_i,
  input  dlac_pkg::dlac_cfg_t   cfg_i,
  input  dlac_pkg::dlac_in_t    tick_i,
  output dlac_pkg::dlac_state_t st_o,
  output dlac_pkg::dlac_out_t   res_o
);
  import dlac_pkg::*;

  function automatic logic [TICK_W-1:0] load_len(input logic [TICK_W-1:0] n);
    load_len = (n == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : n;
  endfunction

  logic              door, intr, corr;
  logic [TICK_W-1:0] cd_dec;
  logic              exp_dec;
  logic [TICK_W-1:0] bc_inc;
  msg_t              msg;

  mode_t             mode_nxt;
  logic [TICK_W-1:0] cd_nxt;
  logic              exp_nxt;
  logic              shown_nxt;
  logic [TICK_W-1:0] bc_nxt;
  logic              sol_nxt;
  logic              red_nxt;
  logic              grn_nxt;
  logic              buz_nxt;

  assign door = tick_i.door_open;
  assign intr = tick_i.intruder_alarm;
  assign corr = tick_i.correct_event;

  // free-running part of a tick: countdown and blink counter
  assign cd_dec  = (st_i.countdown != '0) ? st_i.countdown - 1'b1 : st_i.countdown;
  assign exp_dec = st_i.expired | (st_i.countdown == {{(TICK_W-1){1'b0}}, 1'b1});
  assign bc_inc  = (st_i.blink_count != '1) ? st_i.blink_count + 1'b1 : st_i.blink_count;

  // next mode, timer and counters
  always_comb begin
    mode_nxt  = st_i.mode;
    cd_nxt    = st_i.countdown;
    exp_nxt   = st_i.expired;
    shown_nxt = st_i.unlock_shown;
    bc_nxt    = st_i.blink_count;
    if (cfg_i.fsm_enable) begin
      cd_nxt  = cd_dec;
      exp_nxt = exp_dec;
      bc_nxt  = bc_inc;
      unique case (st_i.mode)
        MODE_LOCKED: begin
          if (door || intr) begin
            mode_nxt = MODE_ALARM;
            cd_nxt   = load_len(cfg_i.alarm_ticks);
            exp_nxt  = 1'b0;
          end else if (corr) begin
            mode_nxt = MODE_UNLOCKED;
            cd_nxt   = load_len(cfg_i.unlock_ticks);
            exp_nxt  = 1'b0;
          end
        end
        MODE_UNLOCKED: begin
          shown_nxt = 1'b1;
          if (door) begin
            shown_nxt = 1'b0;
            mode_nxt  = MODE_OPENED;
          end else if (exp_dec) begin
            shown_nxt = 1'b0;
            exp_nxt   = 1'b0;
            mode_nxt  = MODE_LOCKED;
          end
        end
        MODE_OPENED: begin
          if (!door) begin
            mode_nxt = MODE_CLOSEDW;
            cd_nxt   = load_len(cfg_i.closed_show_ticks);
            exp_nxt  = 1'b0;
          end
        end
        MODE_CLOSEDW: begin
          if (exp_dec) begin
            exp_nxt  = 1'b0;
            mode_nxt = MODE_LOCKED;
          end
        end
        MODE_WAITCL: begin
          if (!door) begin
            mode_nxt = MODE_CLOSEDW;
            cd_nxt   = load_len(cfg_i.closed_show_ticks);
            exp_nxt  = 1'b0;
          end else if (exp_dec) begin
            mode_nxt = MODE_ALARM;
            cd_nxt   = load_len(cfg_i.alarm_ticks);
            exp_nxt  = 1'b0;
          end
        end
        MODE_ALARM: begin
          if (bc_inc > cfg_i.blink_ticks) bc_nxt = '0;
          if (exp_dec) begin
            exp_nxt = 1'b0;
            if (door) begin
              mode_nxt = MODE_WAITCL;
              cd_nxt   = load_len(cfg_i.open_timeout_ticks);
            end else begin
              mode_nxt = MODE_LOCKED;
            end
          end else if (!door && !intr) begin
            exp_nxt  = 1'b0;
            mode_nxt = MODE_LOCKED;
          end
        end
        default: mode_nxt = MODE_LOCKED;
      endcase
    end
  end

  // output latches and message
  always_comb begin
    sol_nxt = st_i.solenoid;
    red_nxt = st_i.red;
    grn_nxt = st_i.green;
    buz_nxt = st_i.buzzer;
    msg     = MSG_NONE;
    if (cfg_i.fsm_enable) begin
      unique case (st_i.mode)
        MODE_LOCKED: begin
          sol_nxt = 1'b0;
          red_nxt = 1'b1;
          grn_nxt = 1'b0;
          if (door) begin
            buz_nxt = 1'b1;
            msg     = MSG_BREACH;
          end else if (intr) begin
            buz_nxt = 1'b1;
          end else if (corr) begin
            sol_nxt = 1'b1;
            red_nxt = 1'b0;
            grn_nxt = 1'b1;
          end
        end
        MODE_UNLOCKED: begin
          if (!st_i.unlock_shown) msg = MSG_UNLOCK;
          if (door)         msg = MSG_OPENED;
          else if (exp_dec) msg = MSG_INPUT;
        end
        MODE_OPENED: begin
          if (!door) msg = MSG_CLOSED;
        end
        MODE_CLOSEDW: begin
          if (exp_dec) msg = MSG_INPUT;
        end
        MODE_WAITCL: begin
          sol_nxt = 1'b0;
          red_nxt = 1'b1;
          grn_nxt = 1'b0;
          if (!door) begin
            msg = MSG_CLOSED;
          end else if (exp_dec) begin
            buz_nxt = 1'b1;
            msg     = MSG_WARNING;
          end
        end
        MODE_ALARM: begin
          if (bc_inc > cfg_i.blink_ticks) red_nxt = ~st_i.red;
          if (exp_dec) begin
            buz_nxt = 1'b0;
            msg     = door ? MSG_CLOSEDR : MSG_INPUT;
          end else if (!door && !intr) begin
            buz_nxt = 1'b0;
            msg     = MSG_INPUT;
          end
        end
        default: msg = MSG_NONE;
      endcase
    end
  end

  assign st_o = '{mode:         mode_nxt,
                  countdown:    cd_nxt,
                  expired:      exp_nxt,
                  unlock_shown: shown_nxt,
                  blink_count:  bc_nxt,
                  solenoid:     sol_nxt,
                  red:          red_nxt,
                  green:        grn_nxt,
                  buzzer:       buz_nxt};

  assign res_o = '{solenoid_on:      sol_nxt,
                   red_led:          red_nxt,
                   green_led:        grn_nxt,
                   buzzer_on:        buz_nxt,
                   door_mode:        mode_nxt,
                   unlocked_or_open: (mode_nxt == MODE_UNLOCKED) ||
                                     (mode_nxt == MODE_OPENED) ||
                                     (mode_nxt == MODE_CLOSEDW),
                   message:          msg};

endmodule
